@@ hw/rtl/vpa_pkg.sv @@
// vpa_pkg: shared constants, entry types and state encoding for the
// variable partition allocator. No dependencies.
package vpa_pkg;

  localparam int unsigned FREE_ENTRIES = 16;
  localparam int unsigned USED_ENTRIES = 16;
  localparam int unsigned ADDR_BITS    = 16;
  localparam int unsigned ID_BITS      = 8;

  localparam int unsigned FIDX_W = $clog2(FREE_ENTRIES);
  localparam int unsigned UIDX_W = $clog2(USED_ENTRIES);
  localparam int unsigned FCNT_W = $clog2(FREE_ENTRIES + 1);
  localparam int unsigned UCNT_W = $clog2(USED_ENTRIES + 1);
  localparam int unsigned CNT_W  = (FCNT_W > UCNT_W) ? FCNT_W : UCNT_W;

  // request codes
  localparam logic [1:0] REQ_ADD   = 2'd0;
  localparam logic [1:0] REQ_ALLOC = 2'd1;
  localparam logic [1:0] REQ_FREE  = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOFIT    = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  // fit policy codes
  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_NEXT  = 2'd1;
  localparam logic [1:0] FIT_BEST  = 2'd2;

  typedef struct packed {
    logic [ADDR_BITS-1:0] start;
    logic [ADDR_BITS-1:0] len;
  } free_ent_t;

  typedef struct packed {
    logic [ID_BITS-1:0]   owner;
    logic [ADDR_BITS-1:0] start;
    logic [ADDR_BITS-1:0] len;
  } used_ent_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_POS,
    S_INS_SH,
    S_INS_WR,
    S_FIT,
    S_FREM_SH,
    S_USCAN,
    S_NB,
    S_UREM,
    S_DONE
  } state_e;

endpackage

@@ hw/rtl/vpa_ram.sv @@
// vpa_ram: generic one-write, one-read synchronous ram with registered
// read data. No dependencies.
module vpa_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/vpa_cfg.sv @@
// vpa_cfg: apb register slave holding the fit policy register.
// Depends on vpa_pkg.
module vpa_cfg
  import vpa_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [1:0]  policy_o
);

  logic [1:0] policy_q, policy_d;
  logic       wr_en;

  // register 0 decodes on the word index bit
  assign wr_en = psel && penable && pwrite && !paddr[2];

  always_comb begin
    policy_d = policy_q;
    if (wr_en) begin
      policy_d = pwdata[1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= FIT_FIRST;
    end else begin
      policy_q <= policy_d;
    end
  end

  assign prdata   = paddr[2] ? 32'd0 : {30'd0, policy_q};
  assign pready   = 1'b1;
  assign policy_o = policy_q;

endmodule

@@ hw/rtl/variable_partition_allocator.sv @@
// variable_partition_allocator: top level with the request sequencer and the
// free and allocated region tables. Depends on vpa_pkg, vpa_ram, vpa_cfg.
//
// Usage: drive req_type_i, job_id_i, region_size_i and region_start_i and
// raise start while busy is low; the request transfers at that edge and
// busy rises. Exactly one result follows: done_o is high for one cycle
// with status_o, granted_start_o and granted_length_o, then busy falls.
// The receiver cannot stall; the result must be taken in that cycle.
// Every table pass reads one entry per cycle from its ram through the ram's
// registered read port. Add: a position scan of the free table, a shift of
// up to fc entries and one write. Allocate: a fit scan of the free table
// plus a removal shift when a region is used up. Free: a scan of the
// allocated table, a neighbor scan of the free table, optional insert or
// merge-removal, and a shift of the allocated table. Reset empties both tables
// by clearing their counts; no clearing pass. fit_policy is written over
// apb at address 0 by the user, only while idle; the block never checks it.
module variable_partition_allocator
  import vpa_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           req_type_i,
  input  logic [ID_BITS-1:0]   job_id_i,
  input  logic [ADDR_BITS-1:0] region_size_i,
  input  logic [ADDR_BITS-1:0] region_start_i,
  output logic                 done_o,
  output logic [1:0]           status_o,
  output logic [ADDR_BITS-1:0] granted_start_o,
  output logic [ADDR_BITS-1:0] granted_length_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  state_e state_q, state_d;

  logic [1:0]           policy;
  logic [1:0]           req_q, req_d;
  logic [ID_BITS-1:0]   id_q, id_d;
  logic [ADDR_BITS-1:0] size_q, size_d, s_q, s_d;
  logic [FCNT_W-1:0]    fc_q, fc_d, rov_q, rov_d;
  logic [UCNT_W-1:0]    uc_q, uc_d;
  logic [CNT_W-1:0]     ix_q, ix_d, cnt_q, cnt_d, tot_q, tot_d, tag_q, tag_d;
  logic [CNT_W-1:0]     k_q, k_d, n_q, n_d, u_q, u_d;
  logic                 pv_q, pv_d, f1_q, f1_d, f2_q, f2_d;
  logic [ADDR_BITS-1:0] kst_q, kst_d, klen_q, klen_d, nlen_q, nlen_d;
  logic [1:0]           st_q, st_d;
  logic [ADDR_BITS-1:0] gs_q, gs_d, gl_q, gl_d;

  logic                 f_we, u_we;
  logic [FIDX_W-1:0]    f_wa;
  logic [UIDX_W-1:0]    u_wa;
  free_ent_t            f_wd, fd;
  used_ent_t            u_wd, ud;

  logic                 accept, issue, pass_end;
  logic [CNT_W-1:0]     fc_x, uc_x, ix_inc, ix_wrap, pos, base;
  logic [ADDR_BITS-1:0] newlen, end_addr;
  logic                 used_up, both_nb, fit_hit;

  vpa_cfg u_cfg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .policy_o (policy)
  );

  vpa_ram #(.Width($bits(free_ent_t)), .Depth(FREE_ENTRIES)) u_free_ram (
    .clk_i   (clk_i),
    .we_i    (f_we),
    .waddr_i (f_wa),
    .wdata_i (f_wd),
    .raddr_i (ix_q[FIDX_W-1:0]),
    .rdata_o (fd)
  );

  vpa_ram #(.Width($bits(used_ent_t)), .Depth(USED_ENTRIES)) u_used_ram (
    .clk_i   (clk_i),
    .we_i    (u_we),
    .waddr_i (u_wa),
    .wdata_i (u_wd),
    .raddr_i (ix_q[UIDX_W-1:0]),
    .rdata_o (ud)
  );

  assign accept   = start && (state_q == S_IDLE);
  assign fc_x     = CNT_W'(fc_q);
  assign uc_x     = CNT_W'(uc_q);
  assign issue    = cnt_q < tot_q;
  // last read has returned and been processed
  assign pass_end = (cnt_q == tot_q) && !pv_q;
  assign ix_inc   = ix_q + CNT_W'(1);
  assign ix_wrap  = (ix_inc == fc_x) ? '0 : ix_inc;
  assign pos      = f1_q ? k_q : fc_x;
  assign base     = (rov_q < fc_q) ? CNT_W'(rov_q) : '0;
  assign newlen   = klen_q - size_q;
  assign used_up  = (newlen == '0);
  assign end_addr = s_q + size_q;
  assign both_nb  = f1_q && f2_q && (k_q != n_q);
  assign fit_hit  = fd.len >= size_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (req_type_i)
            REQ_ADD: begin
              if (region_size_i == '0 || fc_q >= FCNT_W'(FREE_ENTRIES)) begin
                state_d = S_DONE;
              end else begin
                state_d = S_POS;
              end
            end
            REQ_ALLOC: begin
              state_d = (uc_q >= UCNT_W'(USED_ENTRIES)) ? S_DONE : S_FIT;
            end
            REQ_FREE: state_d = S_USCAN;
            default:  state_d = S_DONE;
          endcase
        end
      end
      S_POS:    if (pass_end) state_d = S_INS_SH;
      S_INS_SH: if (pass_end) state_d = S_INS_WR;
      S_INS_WR: state_d = (req_q == REQ_FREE) ? S_UREM : S_DONE;
      S_FIT: begin
        if (pass_end) begin
          state_d = (f1_q && used_up) ? S_FREM_SH : S_DONE;
        end
      end
      S_FREM_SH: begin
        if (pass_end) state_d = (req_q == REQ_ALLOC) ? S_DONE : S_UREM;
      end
      S_USCAN: if (pass_end) state_d = f1_q ? S_NB : S_DONE;
      S_NB: begin
        if (pass_end) begin
          if (both_nb) begin
            state_d = S_FREM_SH;
          end else if (f1_q || f2_q || size_q == '0) begin
            state_d = S_UREM;
          end else if (fc_q >= FCNT_W'(FREE_ENTRIES)) begin
            state_d = S_DONE;
          end else begin
            state_d = S_POS;
          end
        end
      end
      S_UREM:  if (pass_end) state_d = S_DONE;
      S_DONE:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and table accesses
  always_comb begin
    req_d  = req_q;  id_d   = id_q;   size_d = size_q; s_d    = s_q;
    fc_d   = fc_q;   uc_d   = uc_q;   rov_d  = rov_q;
    ix_d   = ix_q;   cnt_d  = cnt_q;  tot_d  = tot_q;  tag_d  = tag_q;
    k_d    = k_q;    n_d    = n_q;    u_d    = u_q;
    f1_d   = f1_q;   f2_d   = f2_q;   pv_d   = 1'b0;
    kst_d  = kst_q;  klen_d = klen_q; nlen_d = nlen_q;
    st_d   = st_q;   gs_d   = gs_q;   gl_d   = gl_q;
    f_we   = 1'b0;   f_wa   = '0;     f_wd   = '0;
    u_we   = 1'b0;   u_wa   = '0;     u_wd   = '0;

    if (state_q != S_IDLE && state_q != S_DONE && state_q != S_INS_WR && issue) begin
      pv_d  = 1'b1;
      tag_d = ix_q;
      cnt_d = cnt_q + CNT_W'(1);
      case (state_q)
        S_FIT:    ix_d = ix_wrap;
        S_INS_SH: ix_d = ix_q - CNT_W'(1);
        default:  ix_d = ix_inc;
      endcase
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          req_d = req_type_i; id_d = job_id_i;
          size_d = region_size_i; s_d = region_start_i;
          st_d = ST_OK; gs_d = '0; gl_d = '0;
          f1_d = 1'b0; f2_d = 1'b0; cnt_d = '0; ix_d = '0;
          case (req_type_i)
            REQ_ADD: begin
              if (region_size_i == '0) begin
                gs_d = region_start_i;
              end else if (fc_q >= FCNT_W'(FREE_ENTRIES)) begin
                st_d = ST_FULL;
              end else begin
                tot_d = fc_x;
              end
            end
            REQ_ALLOC: begin
              if (uc_q >= UCNT_W'(USED_ENTRIES)) begin
                st_d = ST_FULL;
              end else begin
                // only next fit starts at the roving pointer
                ix_d = (policy == FIT_NEXT) ? base : '0;
                tot_d = fc_x;
              end
            end
            REQ_FREE: tot_d = uc_x;
            default: ;
          endcase
        end
      end
      S_POS: begin
        if (pv_q && !f1_q && fd.start > s_q) begin
          f1_d = 1'b1; k_d = tag_q;
        end
        if (pass_end) begin
          k_d = pos; ix_d = fc_x - CNT_W'(1); cnt_d = '0; tot_d = fc_x - pos;
        end
      end
      S_INS_SH: begin
        if (pv_q) begin
          f_we = 1'b1; f_wa = FIDX_W'(tag_q + CNT_W'(1)); f_wd = fd;
        end
      end
      S_INS_WR: begin
        f_we = 1'b1; f_wa = k_q[FIDX_W-1:0];
        f_wd = '{start: s_q, len: size_q};
        fc_d = fc_q + FCNT_W'(1);
        if (req_q == REQ_ADD) begin
          gs_d = s_q; gl_d = size_q;
        end
        if (req_q == REQ_FREE) begin
          ix_d = u_q + CNT_W'(1); cnt_d = '0; tot_d = uc_x - CNT_W'(1) - u_q;
        end
      end
      S_FIT: begin
        if (pv_q && fit_hit &&
            (!f1_q || (policy == FIT_BEST && fd.len < klen_q))) begin
          f1_d = 1'b1; k_d = tag_q; kst_d = fd.start; klen_d = fd.len;
        end
        if (pass_end) begin
          if (!f1_q) begin
            st_d = ST_NOFIT;
          end else begin
            u_we = 1'b1; u_wa = uc_q[UIDX_W-1:0];
            u_wd = '{owner: id_q, start: kst_q, len: size_q};
            uc_d = uc_q + UCNT_W'(1);
            gs_d = kst_q; gl_d = size_q;
            if (used_up) begin
              ix_d = k_q + CNT_W'(1); cnt_d = '0;
              tot_d = fc_x - CNT_W'(1) - k_q;
              if (policy == FIT_NEXT) rov_d = FCNT_W'(k_q);
            end else begin
              f_we = 1'b1; f_wa = k_q[FIDX_W-1:0];
              f_wd = '{start: kst_q + size_q, len: newlen};
              if (policy == FIT_NEXT) rov_d = FCNT_W'(k_q + CNT_W'(1));
            end
          end
        end
      end
      S_FREM_SH: begin
        if (pv_q) begin
          f_we = 1'b1; f_wa = FIDX_W'(tag_q - CNT_W'(1)); f_wd = fd;
        end
        if (pass_end) begin
          fc_d = fc_q - FCNT_W'(1);
          ix_d = u_q + CNT_W'(1); cnt_d = '0; tot_d = uc_x - CNT_W'(1) - u_q;
        end
      end
      S_USCAN: begin
        if (pv_q && !f1_q && ud.owner == id_q && ud.len == size_q) begin
          f1_d = 1'b1; k_d = tag_q; kst_d = ud.start;
        end
        if (pass_end) begin
          if (!f1_q) begin
            st_d = ST_NOTFOUND;
          end else begin
            u_d = k_q; s_d = kst_q;
            f1_d = 1'b0; f2_d = 1'b0; ix_d = '0; cnt_d = '0; tot_d = fc_x;
          end
        end
      end
      S_NB: begin
        if (pv_q) begin
          if (!f1_q && (fd.start + fd.len) == s_q) begin
            f1_d = 1'b1; k_d = tag_q; kst_d = fd.start; klen_d = fd.len;
          end
          if (!f2_q && fd.start == end_addr) begin
            f2_d = 1'b1; n_d = tag_q; nlen_d = fd.len;
          end
        end
        if (pass_end) begin
          cnt_d = '0;
          // default next pass: drop the allocated entry
          ix_d  = u_q + CNT_W'(1); tot_d = uc_x - CNT_W'(1) - u_q;
          if (both_nb) begin
            f_we = 1'b1; f_wa = k_q[FIDX_W-1:0];
            f_wd = '{start: kst_q, len: klen_q + size_q + nlen_q};
            ix_d = n_q + CNT_W'(1); tot_d = fc_x - CNT_W'(1) - n_q;
          end else if (f1_q) begin
            f_we = 1'b1; f_wa = k_q[FIDX_W-1:0];
            f_wd = '{start: kst_q, len: klen_q + size_q};
          end else if (f2_q) begin
            f_we = 1'b1; f_wa = n_q[FIDX_W-1:0];
            f_wd = '{start: s_q, len: nlen_q + size_q};
          end else if (size_q != '0) begin
            if (fc_q >= FCNT_W'(FREE_ENTRIES)) begin
              st_d = ST_FULL;
            end else begin
              f1_d = 1'b0; ix_d = '0; tot_d = fc_x;
            end
          end
        end
      end
      S_UREM: begin
        if (pv_q) begin
          u_we = 1'b1; u_wa = UIDX_W'(tag_q - CNT_W'(1)); u_wd = ud;
        end
        if (pass_end) begin
          uc_d = uc_q - UCNT_W'(1);
          gs_d = s_q; gl_d = size_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fc_q    <= '0;
      uc_q    <= '0;
      rov_q   <= '0;
      pv_q    <= 1'b0;
      cnt_q   <= '0;
      tot_q   <= '0;
      ix_q    <= '0;
      f1_q    <= 1'b0;
      f2_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      fc_q    <= fc_d;
      uc_q    <= uc_d;
      rov_q   <= rov_d;
      pv_q    <= pv_d;
      cnt_q   <= cnt_d;
      tot_q   <= tot_d;
      ix_q    <= ix_d;
      f1_q    <= f1_d;
      f2_q    <= f2_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q  <= req_d;  id_q   <= id_d;   size_q <= size_d; s_q <= s_d;
    tag_q  <= tag_d;  k_q    <= k_d;    n_q    <= n_d;    u_q <= u_d;
    kst_q  <= kst_d;  klen_q <= klen_d; nlen_q <= nlen_d;
    st_q   <= st_d;   gs_q   <= gs_d;   gl_q   <= gl_d;
  end

  assign busy             = (state_q != S_IDLE);
  assign done_o           = (state_q == S_DONE);
  assign status_o         = st_q;
  assign granted_start_o  = gs_q;
  assign granted_length_o = gl_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |=> !done_o)
    else $error("result strobe longer than one cycle");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   fc_q <= FCNT_W'(FREE_ENTRIES) && uc_q <= UCNT_W'(USED_ENTRIES))
    else $error("table count beyond depth");
  assert property (@(posedge clk_i) disable iff (!rst_ni) accept |=> busy)
    else $error("request transfer did not start work");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (state_q == S_IDLE) |-> (fc_q == $past(fc_q) || $past(state_q) != S_IDLE))
    else $error("free count changed while idle");

endmodule

@@ bench/variable_partition_allocator_tb.sv @@
// variable_partition_allocator_tb: self-checking bench for the allocator; a
// scoreboard class predicts every result from its own copy of the tables.
// Depends on vpa_pkg and the variable_partition_allocator rtl.
module variable_partition_allocator_tb;
  import vpa_pkg::*;

  typedef struct packed {
    logic [1:0]           status;
    logic [ADDR_BITS-1:0] gstart;
    logic [ADDR_BITS-1:0] glen;
  } grant_t;

  class alloc_scoreboard;
    logic [1:0] policy;
    logic [ADDR_BITS-1:0] fs[FREE_ENTRIES], fl[FREE_ENTRIES];
    logic [ADDR_BITS-1:0] us[USED_ENTRIES], ul[USED_ENTRIES];
    logic [ID_BITS-1:0] uo[USED_ENTRIES];
    int fcnt, ucnt, rover;
    grant_t pending[$];
    int errors;

    function new();
      policy = FIT_FIRST; fcnt = 0; ucnt = 0; rover = 0; errors = 0;
    endfunction

    function void free_del(int k);
      for (int i = k; i + 1 < fcnt; i++) begin
        fs[i] = fs[i+1]; fl[i] = fl[i+1];
      end
      fcnt--;
    endfunction

    function void free_ins(logic [ADDR_BITS-1:0] s, logic [ADDR_BITS-1:0] l);
      int pos;
      pos = 0;
      while (pos < fcnt && fs[pos] <= s) pos++;
      for (int i = fcnt; i > pos; i--) begin
        fs[i] = fs[i-1]; fl[i] = fl[i-1];
      end
      fs[pos] = s; fl[pos] = l; fcnt++;
    endfunction

    function void note_request(logic [1:0] rt, logic [ID_BITS-1:0] id,
                               logic [ADDR_BITS-1:0] sz, logic [ADDR_BITS-1:0] st);
      grant_t g;
      bit found, hp, hn;
      int k, p, n, u, base, j;
      logic [ADDR_BITS-1:0] s, e, l;
      g = '0; found = 0; k = 0; hp = 0; hn = 0; p = 0; n = 0; u = 0;
      if (rt == REQ_ADD) begin
        if (sz != 0) begin
          if (fcnt >= FREE_ENTRIES) g.status = ST_FULL;
          else free_ins(st, sz);
        end
        if (g.status == ST_OK) begin g.gstart = st; g.glen = sz; end
      end else if (rt == REQ_ALLOC) begin
        if (ucnt >= USED_ENTRIES) g.status = ST_FULL;
        else begin
          if (policy == FIT_NEXT) begin
            base = (rover < fcnt) ? rover : 0;
            for (int i = 0; i < fcnt && !found; i++) begin
              j = base + i;
              if (j >= fcnt) j -= fcnt;
              if (fl[j] >= sz) begin found = 1; k = j; end
            end
          end else if (policy == FIT_BEST) begin
            for (int i = 0; i < fcnt; i++)
              if (fl[i] >= sz && (!found || fl[i] < fl[k])) begin found = 1; k = i; end
          end else begin
            for (int i = 0; i < fcnt && !found; i++)
              if (fl[i] >= sz) begin found = 1; k = i; end
          end
          if (!found) g.status = ST_NOFIT;
          else begin
            g.gstart = fs[k]; g.glen = sz;
            us[ucnt] = fs[k]; ul[ucnt] = sz; uo[ucnt] = id; ucnt++;
            fs[k] = fs[k] + sz; fl[k] = fl[k] - sz;
            if (fl[k] == 0) begin
              free_del(k);
              if (policy == FIT_NEXT) rover = k;
            end else if (policy == FIT_NEXT) rover = k + 1;
          end
        end
      end else if (rt == REQ_FREE) begin
        for (int i = 0; i < ucnt && !found; i++)
          if (uo[i] == id && ul[i] == sz) begin found = 1; u = i; end
        if (!found) g.status = ST_NOTFOUND;
        else begin
          s = us[u]; l = ul[u]; e = s + l;
          for (int i = 0; i < fcnt; i++) begin
            if (!hp && ADDR_BITS'(fs[i] + fl[i]) == s) begin hp = 1; p = i; end
            if (!hn && fs[i] == e) begin hn = 1; n = i; end
          end
          if (hp && hn && p != n) begin
            fl[p] = fl[p] + l + fl[n]; free_del(n);
          end else if (hp) fl[p] = fl[p] + l;
          else if (hn) begin fs[n] = s; fl[n] = fl[n] + l; end
          else if (l != 0) begin
            if (fcnt >= FREE_ENTRIES) g.status = ST_FULL;
            else free_ins(s, l);
          end
          if (g.status == ST_OK) begin
            for (int i = u; i + 1 < ucnt; i++) begin
              us[i] = us[i+1]; ul[i] = ul[i+1]; uo[i] = uo[i+1];
            end
            ucnt--;
            g.gstart = s; g.glen = l;
          end
        end
      end
      pending = {pending, g};
    endfunction

    function void check_result(grant_t got);
      grant_t x;
      if (pending.size() == 0) begin
        $error("result with nothing expected");
        errors++;
        return;
      end
      x = pending.pop_front();
      if (got.status !== x.status) begin
        $error("status exp %0d got %0d", x.status, got.status); errors++;
      end
      if (got.gstart !== x.gstart) begin
        $error("granted_start exp %0h got %0h", x.gstart, got.gstart); errors++;
      end
      if (got.glen !== x.glen) begin
        $error("granted_length exp %0h got %0h", x.glen, got.glen); errors++;
      end
    endfunction
  endclass

  logic clk_i = 0, rst_ni = 0;
  logic start = 0, busy;
  logic [1:0] req_type_i = 0;
  logic [ID_BITS-1:0] job_id_i = 0;
  logic [ADDR_BITS-1:0] region_size_i = 0, region_start_i = 0;
  logic done_o;
  logic [1:0] status_o;
  logic [ADDR_BITS-1:0] granted_start_o, granted_length_o;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [2:0] paddr = 0;
  logic [31:0] pwdata = 0, prdata;
  logic pready;

  alloc_scoreboard board = new();
  int send_idle = 19;
  int cycles = 0;
  logic [ID_BITS-1:0] live_id[$];
  logic [ADDR_BITS-1:0] live_len[$];

  always #4 clk_i = ~clk_i;

  variable_partition_allocator i_dut (.*);

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (done_o) board.check_result({status_o, granted_start_o, granted_length_o});
    if (cycles > 2000000) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic write_policy(logic [1:0] v);
    @(posedge clk_i);
    psel <= 1; pwrite <= 1; paddr <= 0; pwdata <= 32'(v);
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
    board.policy = v;
  endtask

  // one transfer; the prediction is made at the accepting edge
  task automatic send(logic [1:0] rt, logic [ID_BITS-1:0] id,
                      logic [ADDR_BITS-1:0] sz, logic [ADDR_BITS-1:0] st);
    while ($urandom_range(99) < send_idle) @(posedge clk_i);
    start <= 1; req_type_i <= rt; job_id_i <= id;
    region_size_i <= sz; region_start_i <= st;
    do @(posedge clk_i); while (busy);
    board.note_request(rt, id, sz, st);
    if (rt == REQ_ALLOC) begin live_id = {live_id, id}; live_len = {live_len, sz}; end
    start <= 0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    while (board.pending.size() != 0 && guard < 2000) begin
      @(posedge clk_i); guard++;
    end
    repeat (100) @(posedge clk_i);
  endtask

  task automatic random_phase(int count);
    int r, q;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < 30)
        send(REQ_ADD, 8'($urandom), ($urandom_range(9) == 0) ? 16'($urandom)
             : 16'($urandom_range(1, 300)), 16'($urandom_range(0, 40)) * 16'd256);
      else if (r < 65)
        send(REQ_ALLOC, 8'($urandom), ($urandom_range(19) == 0) ? 16'($urandom)
             : 16'($urandom_range(0, 120)), 16'($urandom));
      else if (r < 92 && live_id.size() != 0) begin
        q = $urandom_range(live_id.size() - 1);
        send(REQ_FREE, live_id[q], live_len[q], 16'($urandom));
        live_id.delete(q); live_len.delete(q);
      end else
        send(2'($urandom), 8'($urandom), 16'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // directed: extremes, zero sizes, coalescing, full tables, unknown codes
    send(REQ_ALLOC, 8'h00, 16'h0000, 16'h0000);
    send(REQ_ADD, 8'h00, 16'h0000, 16'hffff);
    send(REQ_ADD, 8'hff, 16'h0100, 16'h1000);
    send(REQ_ADD, 8'h00, 16'h0100, 16'h1200);
    send(REQ_ADD, 8'h00, 16'h0010, 16'hfff8);
    send(REQ_ALLOC, 8'h01, 16'h0000, 16'h0000);
    send(REQ_ALLOC, 8'hff, 16'h0100, 16'h0000);
    send(REQ_ALLOC, 8'h02, 16'hffff, 16'hffff);
    send(REQ_ALLOC, 8'h03, 16'h0080, 16'h0000);
    send(REQ_FREE, 8'h09, 16'h0080, 16'h0000);
    send(REQ_FREE, 8'hff, 16'h0100, 16'h0000);
    send(REQ_FREE, 8'h01, 16'h0000, 16'h0000);
    send(REQ_FREE, 8'h03, 16'h0080, 16'h0000);
    send(2'd3, 8'hff, 16'hffff, 16'hffff);
    send(REQ_ALLOC, 8'h04, 16'h0010, 16'h0000);
    send(REQ_FREE, 8'h04, 16'h0010, 16'h0000);
    for (int i = 0; i < 17; i++) send(REQ_ADD, 8'(i), 16'h0001, 16'(i * 4));
    for (int i = 0; i < 17; i++) send(REQ_ALLOC, 8'(i), 16'h0000, 16'h0000);
    drain();
    write_policy(FIT_NEXT);
    random_phase(250);
    drain();
    write_policy(FIT_BEST);
    random_phase(250);
    drain();
    send_idle = 55;
    write_policy(2'd3);
    random_phase(250);
    drain();
    write_policy(FIT_FIRST);
    random_phase(250);
    drain();
    send_idle = 0;
    write_policy(FIT_NEXT);
    random_phase(300);
    drain();
    write_policy(FIT_BEST);
    random_phase(250);
    drain();
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
